// File: src/mm3_pkg.sv
// Package: MurmurHash3 x86_32 constants, queue item type, back-end states and helpers.
package mm3_pkg;

   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] MIX_MUL = 32'd5;
   localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

   // bytes in a full word
   localparam logic [2:0] WORD_BYTES = 3'd4;

   // one classified item as it travels from front end to back end
   typedef struct packed {
      logic [31:0] word;   // masked data
      logic [2:0]  count;  // effective byte count, 0..4
      logic        last;   // final item of the message
      logic        full;   // four bytes: full block fold
   } item_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX1,
      ST_MIX2,
      ST_FOLD,
      ST_FIN0,
      ST_FIN1,
      ST_OUT
   } back_state_type;

   function automatic logic [31:0] rotl_13(input logic [31:0] x);
      return {x[18:0], x[31:19]};
   endfunction

   function automatic logic [31:0] rotl_15(input logic [31:0] x);
      return {x[16:0], x[31:17]};
   endfunction

endpackage

// File: src/mm3_ifs.sv
// Interfaces: request, response and configuration write channels.
interface mm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last;
   modport source (output valid, data_word, byte_count, last, input ready);
   modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface mm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

interface mm3_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: src/mm3_front.sv
// Front end: takes request transfers, normalizes byte count and masks unused bytes.
module mm3_front (
   mm3_req_if.sink               req_if,
   input  mm3_pkg::queue_status_type q_status,
   output logic                  push,
   output mm3_pkg::item_type     push_item
);

   logic [2:0]  count;
   logic [31:0] mask;

   // accept whenever the queue has room
   assign req_if.ready = !q_status.full;
   assign push         = req_if.valid && req_if.ready;

   // non-final items are whole words; oversized final counts saturate
   always_comb begin
      priority if (!req_if.last) begin
         count = mm3_pkg::WORD_BYTES;
      end else if (req_if.byte_count > mm3_pkg::WORD_BYTES) begin
         count = mm3_pkg::WORD_BYTES;
      end else begin
         count = req_if.byte_count;
      end
   end

   // keep only the valid low bytes
   always_comb begin
      unique case (count)
         3'd0:    mask = 32'h0000_0000;
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      push_item.word  = req_if.data_word & mask;
      push_item.count = count;
      push_item.last  = req_if.last;
      push_item.full  = (count == mm3_pkg::WORD_BYTES);
   end

endmodule

// File: src/mm3_queue.sv
// Queue: small FIFO of classified items between front end and back end.
module mm3_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mm3_pkg::item_type         push_item,
   input  logic                      pop,
   output mm3_pkg::item_type         pop_item,
   output mm3_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mm3_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   // pointer wrap and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/mm3_back.sv
// Back end: multi-cycle scramble, fold and finalize sequencer with output register.
module mm3_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [31:0]               seed,
   input  mm3_pkg::queue_status_type q_status,
   input  mm3_pkg::item_type         pop_item,
   output logic                      pop,
   mm3_rsp_if.source                 rsp_if
);

   mm3_pkg::back_state_type state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] k_ff, k_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        full_ff, full_in;
   logic [31:0] out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] hx;
   logic [31:0] fx;

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.hash_value = out_ff;

   // running hash mixed with the scrambled word, and with the length
   assign hx = h_ff ^ k_ff;
   assign fx = h_ff ^ len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm3_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      len_ff  <= len_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      full_ff <= full_in;
      out_ff  <= out_in;
   end

   // sequencer: at most one multiply per step
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      h_in         = h_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      pop          = 1'b0;

      // result taken by the receiver
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         mm3_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               k_in    = pop_item.word;
               cnt_in  = pop_item.count;
               last_in = pop_item.last;
               full_in = pop_item.full;
               h_in    = busy_ff ? h_ff : seed;
               len_in  = busy_ff ? len_ff : 32'd0;
               busy_in = 1'b1;
               state_in = (pop_item.count == 3'd0) ? mm3_pkg::ST_FIN0 : mm3_pkg::ST_MIX1;
            end
         end
         mm3_pkg::ST_MIX1: begin
            k_in     = k_ff * mm3_pkg::MIX_C1;
            state_in = mm3_pkg::ST_MIX2;
         end
         mm3_pkg::ST_MIX2: begin
            k_in     = mm3_pkg::rotl_15(k_ff) * mm3_pkg::MIX_C2;
            state_in = mm3_pkg::ST_FOLD;
         end
         mm3_pkg::ST_FOLD: begin
            h_in     = full_ff ? mm3_pkg::rotl_13(hx) * mm3_pkg::MIX_MUL + mm3_pkg::MIX_ADD
                               : hx;
            len_in   = len_ff + 32'(cnt_ff);
            state_in = last_ff ? mm3_pkg::ST_FIN0 : mm3_pkg::ST_IDLE;
         end
         mm3_pkg::ST_FIN0: begin
            k_in     = (fx ^ (fx >> 16)) * mm3_pkg::FIN_C1;
            state_in = mm3_pkg::ST_FIN1;
         end
         mm3_pkg::ST_FIN1: begin
            k_in     = (k_ff ^ (k_ff >> 13)) * mm3_pkg::FIN_C2;
            state_in = mm3_pkg::ST_OUT;
         end
         mm3_pkg::ST_OUT: begin
            // wait while an older result is still stalled
            if (!out_valid_ff || rsp_if.ready) begin
               out_in       = k_ff ^ (k_ff >> 16);
               out_valid_in = 1'b1;
               busy_in      = 1'b0;
               state_in     = mm3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm3_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/murmur3_32_stream_hash.sv
// Top level: MurmurHash3 x86_32 stream hash with seed register, front end, queue, back end.
//
// Usage:
//   req_if  : message words, little endian, first byte in bits 7:0. byte_count
//             gives valid bytes (non-final items always count as four); last
//             marks the final item, which may hold 0 to 4 bytes.
//   rsp_if  : one finalized hash per message, after its last item.
//   csr_if  : write of the seed; always ready. Write only while idle. The seed
//             is sampled when the first item of a message starts processing.
// Sequence: the back end runs at most one 32x32 multiply per step, through
//   IDLE (pop), MIX1, MIX2 and FOLD for each item with data, then FIN0, FIN1
//   and OUT after a final item; an empty final item goes from IDLE to FIN0.
// Path: a last item passes through the queue, the back-end states and the
//   output register before rsp valid rises.
// The front end keeps taking items into a QUEUE_DEPTH-entry queue while the
//   back end works, and the back end keeps working while a result waits in the
//   output register; it holds only when a new result meets a stalled one.
// Reset clears the queue, the sequencer, the output valid and the seed (0).
module murmur3_32_stream_hash #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   mm3_req_if.sink    req_if,
   mm3_rsp_if.source  rsp_if,
   mm3_csr_if.sink    csr_if
);

   logic [31:0]               seed_ff, seed_in;
   logic                      push;
   logic                      pop;
   mm3_pkg::item_type         push_item;
   mm3_pkg::item_type         pop_item;
   mm3_pkg::queue_status_type q_status;

   // seed register
   assign csr_if.ready = 1'b1;
   assign seed_in      = (csr_if.valid && csr_if.ready) ? csr_if.data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm3_front u_front (
      .req_if    (req_if),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   mm3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   mm3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .seed     (seed_ff),
      .q_status (q_status),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

// File: src/mm3_checker.sv
// Checker: port-level assertions for the stream hash, bound to the top level.
module mm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   // reset leaves no result pending
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset empties the queue, so requests are taken right away
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("req not ready after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash_value)))
      else $error("stalled rsp changed");

endmodule

bind murmur3_32_stream_hash mm3_checker u_mm3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_hash_value (rsp_if.hash_value)
);

// File: test/tb_murmur3_32_stream_hash.sv
// Testbench for murmur3_32_stream_hash: directed and random messages checked against a predictor.
`timescale 1ns / 1ps

module tb_murmur3_32_stream_hash;

   // hash constants, kept local to the predictor
   localparam logic [31:0] K_MUL1   = 32'hcc9e2d51;
   localparam logic [31:0] K_MUL2   = 32'h1b873593;
   localparam logic [31:0] K_ADD    = 32'he6546b64;
   localparam logic [31:0] K_FMIX1  = 32'h85ebca6b;
   localparam logic [31:0] K_FMIX2  = 32'hc2b2ae35;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_ITEMS   = 200;
   localparam int NUM_PHASES    = 8;
   localparam int NUM_DIRECTED  = 18;

   logic clock;
   logic reset;

   mm3_req_if req_if ();
   mm3_rsp_if rsp_if ();
   mm3_csr_if csr_if ();

   murmur3_32_stream_hash dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // one row of the directed stimulus
   typedef struct {
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
      logic        has_typed;
      logic [31:0] typed_hash;
   } stim_row_type;

   // predictor state
   logic [31:0] seed_reg;
   logic [31:0] run_hash;
   logic [31:0] msg_len;
   logic        in_msg;
   logic [31:0] expected_hashes[$];

   // known hash riding along with the item that finalizes a message
   logic        typed_valid;
   logic [31:0] typed_hash;

   int  cycle_count;
   int  error_count;
   int  items_sent;
   int  items_taken;
   int  messages_taken;
   int  hashes_checked;
   int  seed_writes;
   bit  no_gaps;
   bit  hold_request;
   int  holds_done;

   stim_row_type directed_rows[NUM_DIRECTED];

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      k = k * K_MUL1;
      k = rotl32(k, 15);
      return k * K_MUL2;
   endfunction

   function automatic logic [31:0] mix_block(input logic [31:0] h, input logic [31:0] w);
      h = h ^ scramble_word(w);
      h = rotl32(h, 13);
      return h * 32'd5 + K_ADD;
   endfunction

   function automatic logic [31:0] fmix32(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * K_FMIX1;
      h = h ^ (h >> 13);
      h = h * K_FMIX2;
      return h ^ (h >> 16);
   endfunction

   // advance the running hash by one accepted item; queue the hash on a final item
   task automatic hash_item(input logic [31:0] w, input logic [2:0] c, input logic l);
      logic [31:0] h;
      logic [31:0] len;
      logic [2:0]  n;
      h   = in_msg ? run_hash : seed_reg;
      len = in_msg ? msg_len : 32'd0;
      if (!l) begin
         run_hash = mix_block(h, w);
         msg_len  = len + 32'd4;
         in_msg   = 1'b1;
      end else begin
         n = (c > 3'd4) ? 3'd4 : c;
         if (n == 3'd4)
            h = mix_block(h, w);
         else if (n != 3'd0)
            h = h ^ scramble_word(w & ~(32'hffffffff << (8 * n)));
         len = len + 32'(n);
         h = fmix32(h ^ len);
         expected_hashes.push_back(typed_valid ? typed_hash : h);
         run_hash = seed_reg;
         msg_len  = 32'd0;
         in_msg   = 1'b0;
         messages_taken++;
      end
      items_taken++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d hashes still pending",
               cycle_count, expected_hashes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // observe transfers on all three channels at the clock edge
   always @(posedge clock) begin
      logic [31:0] exp_hash;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            seed_reg = csr_if.data;
         if (req_if.valid && req_if.ready)
            hash_item(req_if.data_word, req_if.byte_count, req_if.last);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: hash %08h arrived with none expected", $time, rsp_if.hash_value);
               error_count++;
            end else begin
               exp_hash = expected_hashes.pop_front();
               hashes_checked++;
               if (rsp_if.hash_value !== exp_hash) begin
                  $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                           $time, exp_hash, rsp_if.hash_value);
                  error_count++;
               end
            end
         end
      end
   end

   // result side: random back-pressure, plus one long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            for (int n = 1; n < HOLD_CYCLES; n++)
               @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else begin
            rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // offer one item and wait for its transfer
   task automatic send_item(input logic [31:0] w, input logic [2:0] c, input logic l,
                            input logic has_typed, input logic [31:0] known_hash);
      if (!no_gaps) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid      <= 1'b1;
      req_if.data_word  <= w;
      req_if.byte_count <= c;
      req_if.last       <= l;
      typed_valid       <= has_typed;
      typed_hash        <= known_hash;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // let the observer catch up on every sent item, every pending hash arrive,
   // then the back end settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_hashes.size() != 0 || items_taken != items_sent)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      wait_idle();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      csr_if.valid <= 1'b0;
      seed_writes++;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h00000000;
         1:       return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   // one message of random content: mostly short, now and then long
   task automatic send_random_message();
      int          n_words;
      logic [2:0]  c;
      n_words = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(5);
      for (int i = 0; i < n_words; i++) begin
         // non-final count is ignored by the block, so vary it now and then
         c = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4;
         send_item(pick_word(), c, 1'b0, 1'b0, 32'd0);
      end
      c = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_item(pick_word(), c, 1'b1, 1'b0, 32'd0);
   endtask

   initial begin
      logic [31:0] phase_seeds[NUM_PHASES];

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.data_word  = '0;
      req_if.byte_count = '0;
      req_if.last       = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.data       = '0;
      typed_valid       = 1'b0;
      typed_hash        = '0;
      seed_reg          = 32'd0;
      run_hash          = 32'd0;
      msg_len           = 32'd0;
      in_msg            = 1'b0;
      error_count       = 0;
      items_sent        = 0;
      items_taken       = 0;
      messages_taken    = 0;
      hashes_checked    = 0;
      seed_writes       = 0;
      holds_done        = 0;
      no_gaps           = 1'b0;
      hold_request      = 1'b0;

      // directed rows, seed at its reset value of zero
      directed_rows = '{
         // empty message with zero seed hashes to zero
         '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
         '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'd0},
         '{32'h00000000, 3'd4, 1'b1, 1'b0, 32'd0},
         // tail bytes, upper bytes set to show they are ignored
         '{32'hdeadbe21, 3'd1, 1'b1, 1'b0, 32'd0},
         '{32'hffff4321, 3'd2, 1'b1, 1'b0, 32'd0},
         '{32'hff654321, 3'd3, 1'b1, 1'b0, 32'd0},
         // oversize final counts act as four
         '{32'h87654321, 3'd7, 1'b1, 1'b0, 32'd0},
         '{32'h87654321, 3'd5, 1'b1, 1'b0, 32'd0},
         '{32'hffffffff, 3'd6, 1'b1, 1'b0, 32'd0},
         // non-final words count as four whatever byte_count says
         '{32'h12345678, 3'd0, 1'b0, 1'b0, 32'd0},
         '{32'hffffffff, 3'd1, 1'b0, 1'b0, 32'd0},
         '{32'ha5a5a5a5, 3'd3, 1'b1, 1'b0, 32'd0},
         // empty final item after data
         '{32'h00000000, 3'd6, 1'b0, 1'b0, 32'd0},
         '{32'hffffffff, 3'd0, 1'b1, 1'b0, 32'd0},
         '{32'hffffffff, 3'd4, 1'b0, 1'b0, 32'd0},
         '{32'hffffffff, 3'd7, 1'b0, 1'b0, 32'd0},
         '{32'h80000001, 3'd4, 1'b1, 1'b0, 32'd0},
         '{32'h5a5a5a5a, 3'd0, 1'b1, 1'b0, 32'd0}
      };

      phase_seeds = '{32'hffffffff, 32'h00000000, $urandom, 32'h80000000,
                      $urandom, 32'h00000001, $urandom, $urandom};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].word, directed_rows[i].count, directed_rows[i].last,
                   directed_rows[i].has_typed, directed_rows[i].typed_hash);

      // random messages, one seed per phase
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_seed(phase_seeds[p]);
         no_gaps = (p == 2);
         if (p == 4)
            hold_request = 1'b1;
         while (items_sent < NUM_DIRECTED + (p + 1) * PHASE_ITEMS)
            send_random_message();
      end

      wait_idle();
      no_gaps = 1'b0;

      $display("Run covered %0d items, %0d messages, %0d hashes checked",
               items_taken, messages_taken, hashes_checked);
      $display("Seed written %0d times incl. both extremes, %0d long output holds",
               seed_writes, holds_done);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d errors", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
